// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg
// Constants shared by the thick polyline triangulator modules.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int LW_W   = 23;              // line_width register width
    localparam int HALF_W = LW_W - 1;        // half width, also quotient width

    localparam logic [LW_W-1:0] LW_RESET = 23'd1966;

    // Register index decoded from the word address
    localparam logic REG_LINE_WIDTH = 1'b0;

    // Per-vertex selection, bit k for vertex k of a segment
    localparam logic [5:0] VTX_FROM_P1 = 6'b101100;
    localparam logic [5:0] VTX_SUB_OFS = 6'b110010;
    localparam logic [2:0] VTX_LAST    = 3'd5;

endpackage

// ===== design/tpt_front.sv =====
// ----------------------------------------------------------------------------
// tpt_front
// Accepts points, keeps the previous point and queues real segments.
// ----------------------------------------------------------------------------
module tpt_front
    import tpt_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [COORD_WIDTH-1:0]   point_x,
    input  logic [COORD_WIDTH-1:0]   point_y,
    input  logic                     end_of_curve,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [4*COORD_WIDTH-1:0] q_data      // p0x, p0y, p1x, p1y
);

    logic [COORD_WIDTH-1:0] prev_x_reg, prev_x_next;
    logic [COORD_WIDTH-1:0] prev_y_reg, prev_y_next;
    logic                   have_prev_reg, have_prev_next;
    logic                   accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // A segment exists only with a stored point and a nonzero displacement
    assign q_push = accept && have_prev_reg &&
                    ((point_x != prev_x_reg) || (point_y != prev_y_reg));
    assign q_data = {point_y, point_x, prev_y_reg, prev_x_reg};

    always_comb
    begin
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        if (accept)
        begin
            if (end_of_curve)
            begin
                prev_x_next    = '0;
                prev_y_next    = '0;
                have_prev_next = 1'b0;
            end
            else
            begin
                prev_x_next    = point_x;
                prev_y_next    = point_y;
                have_prev_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

// ===== design/tpt_queue.sv =====
// ----------------------------------------------------------------------------
// tpt_queue
// Two-entry segment queue between the front and back parts.
// ----------------------------------------------------------------------------
module tpt_queue
    import tpt_pkg::*;
#(
    parameter int DATA_W = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              valid,
    input  logic              pop,
    output logic [DATA_W-1:0] data
);

    `include "assert_macros.svh"

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPL(a_no_overflow, push, count_reg != 2'd2)
    `ASSERT_IMPL(a_no_underflow, pop, count_reg != 2'd0)
    `ASSERT_IMPL(a_count_range, 1'b1, count_reg <= 2'd2)

endmodule

// ===== design/tpt_back.sv =====
// ----------------------------------------------------------------------------
// tpt_back
// Computes the segment offset with a one-bit-per-cycle shift-add, root and
// divide unit, then emits the six triangle vertices through an output register.
// ----------------------------------------------------------------------------
module tpt_back
    import tpt_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [HALF_W-1:0]        half_width,
    input  logic                     q_valid,
    input  logic [4*COORD_WIDTH-1:0] q_data,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COORD_WIDTH-1:0]   vertex_x,
    output logic [COORD_WIDTH-1:0]   vertex_y,
    output logic                     last_vertex
);

    `include "assert_macros.svh"

    localparam int CW    = COORD_WIDTH;
    localparam int RT_W  = CW + 1;                    // root width
    localparam int RAD_W = 2 * RT_W;                  // radicand width
    localparam int ACC_W = (RAD_W > CW + HALF_W) ? RAD_W : CW + HALF_W;
    localparam int MP_W  = (CW > HALF_W) ? CW : HALF_W;
    localparam int RR_W  = RT_W + 3;                  // root remainder
    localparam int DR_W  = RT_W + 1;                  // divide remainder
    localparam int SUM_W = ((CW > HALF_W + 1) ? CW : HALF_W + 1) + 1;
    localparam int CNT_W = $clog2(CW + 1);

    localparam logic signed [SUM_W-1:0] MAX_V =
        {{(SUM_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MIN_V = ~MAX_V;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SQX  = 9'b000000010,
        ST_SQY  = 9'b000000100,
        ST_ROOT = 9'b000001000,
        ST_MULX = 9'b000010000,
        ST_DIVX = 9'b000100000,
        ST_MULY = 9'b001000000,
        ST_DIVY = 9'b010000000,
        ST_EMIT = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]      p0x_reg, p0x_next, p0y_reg, p0y_next;
    logic [CW-1:0]      p1x_reg, p1x_next, p1y_reg, p1y_next;
    logic [CW-1:0]      adx_reg, adx_next, ady_reg, ady_next;
    logic               ox_neg_reg, ox_neg_next, oy_neg_reg, oy_neg_next;
    logic [ACC_W-1:0]   acc_reg, acc_next, mcand_reg, mcand_next;
    logic [MP_W-1:0]    mplier_reg, mplier_next;
    logic [RT_W-1:0]    root_reg, root_next;
    logic [RR_W-1:0]    rrem_reg, rrem_next;
    logic [DR_W-1:0]    drem_reg, drem_next;
    logic [HALF_W-1:0]  quo_reg, quo_next;
    logic [HALF_W-1:0]  mx_reg, mx_next, my_reg, my_next;
    logic [2:0]         k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic [CW-1:0]      out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic               out_last_reg, out_last_next;

    // Queue entry fields
    logic [CW-1:0]      q_p0x, q_p0y, q_p1x, q_p1y;
    logic signed [CW:0] dx, dy;
    logic [CW:0]        adx_full, ady_full;

    // Iteration datapath
    logic [ACC_W-1:0]   prod;
    logic [ACC_W-1:0]   prod_hi;
    logic [RR_W-1:0]    rrem_sh, rtrial;
    logic               rbit;
    logic [RT_W-1:0]    root_step;
    logic [DR_W-1:0]    dtrial, dden;
    logic               dbit;
    logic [HALF_W-1:0]  quo_step;
    logic [DR_W-1:0]    drem_step;

    // Vertex datapath
    logic signed [SUM_W-1:0] ox, oy, bx, by, sx, sy;
    logic               load_vtx;

    function automatic logic [CW-1:0] sat_cw(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        begin
            c = v;
            if (v > MAX_V)
            begin
                c = MAX_V;
            end
            else if (v < MIN_V)
            begin
                c = MIN_V;
            end
            return c[CW-1:0];
        end
    endfunction

    assign {q_p1y, q_p1x, q_p0y, q_p0x} = q_data;

    always_comb
    begin
        dx       = {q_p1x[CW-1], q_p1x} - {q_p0x[CW-1], q_p0x};
        dy       = {q_p1y[CW-1], q_p1y} - {q_p0y[CW-1], q_p0y};
        adx_full = dx[CW] ? (~dx + 1'b1) : dx;
        ady_full = dy[CW] ? (~dy + 1'b1) : dy;
    end

    // Shift-add multiply step
    always_comb
    begin
        prod    = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
        prod_hi = prod >> HALF_W;
    end

    // Digit-by-digit square root step, two radicand bits per cycle
    always_comb
    begin
        rrem_sh   = {rrem_reg[RR_W-3:0], acc_reg[RAD_W-1:RAD_W-2]};
        rtrial    = {1'b0, root_reg, 2'b01};
        rbit      = (rrem_sh >= rtrial);
        root_step = {root_reg[RT_W-2:0], rbit};
    end

    // Restoring divide step against the root
    always_comb
    begin
        dtrial    = {drem_reg[DR_W-2:0], acc_reg[HALF_W-1]};
        dden      = {1'b0, root_reg};
        dbit      = (dtrial >= dden);
        drem_step = dbit ? (dtrial - dden) : dtrial;
        quo_step  = {quo_reg[HALF_W-2:0], dbit};
    end

    // Vertex select and offset; sat_cw saturates the sums when they load the output register
    always_comb
    begin
        ox = SUM_W'(mx_reg);
        oy = SUM_W'(my_reg);
        if (ox_neg_reg)
        begin
            ox = -ox;
        end
        if (oy_neg_reg)
        begin
            oy = -oy;
        end
        if (VTX_FROM_P1[k_reg])
        begin
            bx = SUM_W'(signed'(p1x_reg));
            by = SUM_W'(signed'(p1y_reg));
        end
        else
        begin
            bx = SUM_W'(signed'(p0x_reg));
            by = SUM_W'(signed'(p0y_reg));
        end
        sx = VTX_SUB_OFS[k_reg] ? (bx - ox) : (bx + ox);
        sy = VTX_SUB_OFS[k_reg] ? (by - oy) : (by + oy);
    end

    assign load_vtx = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg - 1'b1;
        p0x_next       = p0x_reg;
        p0y_next       = p0y_reg;
        p1x_next       = p1x_reg;
        p1y_next       = p1y_reg;
        adx_next       = adx_reg;
        ady_next       = ady_reg;
        ox_neg_next    = ox_neg_reg;
        oy_neg_next    = oy_neg_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        root_next      = root_reg;
        rrem_next      = rrem_reg;
        drem_next      = drem_reg;
        quo_next       = quo_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        k_next         = k_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = cnt_reg;
                if (q_valid)
                begin
                    p0x_next    = q_p0x;
                    p0y_next    = q_p0y;
                    p1x_next    = q_p1x;
                    p1y_next    = q_p1y;
                    adx_next    = adx_full[CW-1:0];
                    ady_next    = ady_full[CW-1:0];
                    ox_neg_next = !dy[CW] && (dy != '0);
                    oy_neg_next = dx[CW];
                    acc_next    = '0;
                    mcand_next  = ACC_W'(adx_full[CW-1:0]);
                    mplier_next = MP_W'(adx_full[CW-1:0]);
                    cnt_next    = CNT_W'(CW - 1);
                    state_next  = ST_SQX;
                end
            end
            ST_SQX, ST_SQY, ST_MULX, ST_MULY:
            begin
                acc_next    = prod;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == ST_SQX)
                    begin
                        mcand_next  = ACC_W'(ady_reg);
                        mplier_next = MP_W'(ady_reg);
                        cnt_next    = CNT_W'(CW - 1);
                        state_next  = ST_SQY;
                    end
                    else if (state_reg == ST_SQY)
                    begin
                        root_next  = '0;
                        rrem_next  = '0;
                        cnt_next   = CNT_W'(RT_W - 1);
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        // Preload the dividend bits above the quotient range
                        drem_next  = prod_hi[DR_W-1:0];
                        cnt_next   = CNT_W'(HALF_W - 1);
                        state_next = (state_reg == ST_MULX) ? ST_DIVX : ST_DIVY;
                    end
                end
            end
            ST_ROOT:
            begin
                root_next = root_step;
                rrem_next = rbit ? (rrem_sh - rtrial) : rrem_sh;
                acc_next  = acc_reg << 2;
                if (cnt_reg == '0)
                begin
                    acc_next    = '0;
                    mcand_next  = ACC_W'(ady_reg);
                    mplier_next = MP_W'(half_width);
                    cnt_next    = CNT_W'(HALF_W - 1);
                    state_next  = ST_MULX;
                end
            end
            ST_DIVX, ST_DIVY:
            begin
                drem_next = drem_step;
                quo_next  = quo_step;
                acc_next  = acc_reg << 1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == ST_DIVX)
                    begin
                        mx_next     = quo_step;
                        acc_next    = '0;
                        mcand_next  = ACC_W'(adx_reg);
                        mplier_next = MP_W'(half_width);
                        cnt_next    = CNT_W'(HALF_W - 1);
                        state_next  = ST_MULY;
                    end
                    else
                    begin
                        my_next    = quo_step;
                        k_next     = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                cnt_next = cnt_reg;
                if (load_vtx)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = sat_cw(sx);
                    out_y_next     = sat_cw(sy);
                    out_last_next  = (k_reg == VTX_LAST);
                    k_next         = k_reg + 1'b1;
                    if (k_reg == VTX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p0x_reg    <= p0x_next;
        p0y_reg    <= p0y_next;
        p1x_reg    <= p1x_next;
        p1y_reg    <= p1y_next;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        ox_neg_reg <= ox_neg_next;
        oy_neg_reg <= oy_neg_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        root_reg   <= root_next;
        rrem_reg   <= rrem_next;
        drem_reg   <= drem_next;
        quo_reg    <= quo_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign vertex_x    = out_x_reg;
    assign vertex_y    = out_y_reg;
    assign last_vertex = out_last_reg;

    // A queued segment always has a nonzero length
    `ASSERT_IMPL(a_sumsq_nonzero, $rose(state_reg == ST_ROOT), acc_reg != '0)
    `ASSERT_IMPL(a_root_nonzero, state_reg == ST_DIVX || state_reg == ST_DIVY, root_reg != '0)
    `ASSERT_NEXT(a_last_flagged, load_vtx && k_reg == VTX_LAST, out_valid_reg && out_last_reg)

endmodule

// ===== design/thick_polyline_triangulator.sv =====
// ----------------------------------------------------------------------------
// thick_polyline_triangulator
// Turns a stream of polyline points into two triangles per segment.
// ----------------------------------------------------------------------------
// Points that start a curve or repeat the previous point produce no
// vertices and are taken one per cycle while the two-entry segment queue has
// room. Each real segment occupies the back end while the shared iteration
// unit resolves one bit per cycle through two squares, the square root, and
// two multiply-divide pairs with 22 steps in each multiply and each divide,
// followed by six vertex transactions. Offsets are (-dy, dx) *
// (line_width/2) / floor(length), truncated toward zero, and vertex
// coordinates saturate. line_width sits at byte address 0 and may be
// rewritten only while no segment is in flight.
module thick_polyline_triangulator
    import tpt_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,   // point_x, point_y
    input  logic                                 s_tlast,   // end_of_curve

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,   // vertex_x, vertex_y
    output logic                                 m_tlast,   // last_vertex

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW   = COORD_WIDTH;
    localparam int TD_W = ((2 * CW + 7) / 8) * 8;

    logic [LW_W-1:0]   line_width_reg, line_width_next;
    logic              cfg_write;

    logic              q_push, q_full, q_valid, q_pop;
    logic [4*CW-1:0]   q_in_data, q_out_data;
    logic [CW-1:0]     vertex_x, vertex_y;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_LINE_WIDTH);
    assign prdata    = (paddr[2] == REG_LINE_WIDTH) ? 32'(line_width_reg) : '0;

    always_comb
    begin
        line_width_next = cfg_write ? pwdata[LW_W-1:0] : line_width_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LW_RESET;
        end
        else
        begin
            line_width_reg <= line_width_next;
        end
    end

    tpt_front #(
        .COORD_WIDTH (CW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .point_x      (s_tdata[CW-1:0]),
        .point_y      (s_tdata[2*CW-1:CW]),
        .end_of_curve (s_tlast),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in_data)
    );

    tpt_queue #(
        .DATA_W (4 * CW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_data),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .data      (q_out_data)
    );

    tpt_back #(
        .COORD_WIDTH (CW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_width  (line_width_reg[LW_W-1:1]),
        .q_valid     (q_valid),
        .q_data      (q_out_data),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (m_tlast)
    );

    assign m_tdata = TD_W'({vertex_y, vertex_x});

endmodule
